@@ sv/ctd_pkg.sv @@
// ----------------------------------------------------------------------------
// Capacitive touch dimmer package
// Shared widths, constants, codes and control structs of the dimmer.
// ----------------------------------------------------------------------------
package ctd_pkg;

   // Default width of the charge time fields
   localparam int TIME_BITS_DEF = 8;

   // Fixed field widths
   localparam int RATIO_BITS     = 12;
   localparam int LEVEL_BITS     = 8;
   localparam int PCT_BITS       = 7;
   localparam int CSR_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 1;
   localparam int HOLD_MOD_BITS  = 3;

   // Arithmetic constants
   localparam int RATIO_MAX         = 4095;
   localparam int RATIO_ZERO_SENSOR = 2550;
   localparam int PCT_BASE          = 100;
   localparam int DETECT_PCT_RST    = 25;
   localparam int HOLD_STEP         = 5;

   // Item commands
   localparam logic CMD_CALIBRATE = 1'b0;
   localparam logic CMD_SENSE     = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DETECT_PERCENT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STARTUP_LEVEL  = 1'b1;

   // Request from the sequencer to the hold machine
   typedef struct packed {
      logic                  step;
      logic                  sense;
      logic                  touched;
      logic                  load;
      logic [LEVEL_BITS-1:0] load_level;
   } hold_req_type;

   // Levels the hold machine will show once the current item is committed
   typedef struct packed {
      logic [LEVEL_BITS-1:0] lamp_level;
      logic                  save_pulse;
      logic [LEVEL_BITS-1:0] stored_level;
   } hold_view_type;

endpackage

@@ sv/capacitive_touch_dimmer.sv @@
// ----------------------------------------------------------------------------
// Capacitive touch dimmer
// Calibrates a charge ratio, judges touches and drives a hold-to-dim lamp.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  cmd, ref_time, sensor_time
//   rsp      out        rsp_valid / rsp_stall  touched, lamp_level,
//                                              save_pulse, stored_level
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// An item passes from acceptance through the serial divider, the register of
// its done flag, the threshold compare state and the commit state into the
// result register. The next item can be taken in the same cycle as the
// result appears.
// The divider works one quotient bit per cycle.
// Reset is synchronous; it clears the ratio, the hold machine and the
// saved level, and loads detect_percent with 25.
// A result waiting under rsp_stall does not block the next item; a second
// finished result waits in the commit state until the output is free.
// ----------------------------------------------------------------------------
module capacitive_touch_dimmer
   import ctd_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // input items
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [TIME_BITS-1:0]      req_ref_time,
   input  logic [TIME_BITS-1:0]      req_sensor_time,
   // result items
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_touched,
   output logic [LEVEL_BITS-1:0]     rsp_lamp_level,
   output logic                      rsp_save_pulse,
   output logic [LEVEL_BITS-1:0]     rsp_stored_level,
   // configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int DVD_W  = TIME_BITS + 4;
   localparam int DVS_W  = (TIME_BITS > RATIO_BITS) ? TIME_BITS : RATIO_BITS;
   localparam int PROD_W = DVD_W + PCT_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_CMP,
      ST_COMMIT
   } state_type;

   state_type                state_ff, state_in;
   logic                     cmd_ff, cmd_in;
   logic [TIME_BITS-1:0]     sens_ff, sens_in;
   logic [RATIO_BITS-1:0]    ratio_ff, ratio_in;
   logic                     touched_ff, touched_in;
   logic [PCT_BITS-1:0]      pct_ff, pct_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_touched_ff, rsp_touched_in;
   logic [LEVEL_BITS-1:0]    rsp_lamp_ff, rsp_lamp_in;
   logic                     rsp_save_ff, rsp_save_in;
   logic [LEVEL_BITS-1:0]    rsp_stored_ff, rsp_stored_in;

   logic                     accept;
   logic                     out_free;
   logic                     commit;
   logic                     csr_write;
   logic [DVD_W-1:0]         ref_x10;
   logic [RATIO_BITS-1:0]    ratio_eff;
   logic [DVS_W-1:0]         div_divisor;
   logic                     div_done;
   logic [DVD_W-1:0]         div_quo;
   logic [PCT_BITS:0]        pct_sum;
   logic [PROD_W-1:0]        thr_scaled;
   logic [PROD_W-1:0]        sens_scaled;
   hold_req_type             hold_req;
   hold_view_type            hold_view;

   // Handshakes
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_COMMIT) && out_free;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Divider operands: ref*10 over the sensor time or over the ratio
   assign ref_x10     = (DVD_W'(req_ref_time) << 3) + (DVD_W'(req_ref_time) << 1);
   assign ratio_eff   = (ratio_ff == '0) ? RATIO_BITS'(1) : ratio_ff;
   assign div_divisor = (req_cmd == CMD_CALIBRATE) ? DVS_W'(req_sensor_time)
                                                   : DVS_W'(ratio_eff);

   ctd_serial_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (ref_x10),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // sens > floor(q*(100+p)/100) holds exactly when q*(100+p) < 100*sens
   assign pct_sum     = (PCT_BITS + 1)'(PCT_BASE) + {1'b0, pct_ff};
   assign thr_scaled  = PROD_W'(div_quo) * PROD_W'(pct_sum);
   assign sens_scaled = PROD_W'(sens_ff) * PROD_W'(PCT_BASE);

   // Hold machine
   assign hold_req.step       = commit;
   assign hold_req.sense      = (cmd_ff == CMD_SENSE);
   assign hold_req.touched    = touched_ff;
   assign hold_req.load       = csr_write && (csr_index == CSR_STARTUP_LEVEL);
   assign hold_req.load_level = csr_wdata[LEVEL_BITS-1:0];

   ctd_hold u_hold (
      .clock (clock),
      .reset (reset),
      .req   (hold_req),
      .view  (hold_view)
   );

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      sens_in        = sens_ff;
      ratio_in       = ratio_ff;
      touched_in     = touched_ff;
      pct_in         = pct_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_touched_in = rsp_touched_ff;
      rsp_lamp_in    = rsp_lamp_ff;
      rsp_save_in    = rsp_save_ff;
      rsp_stored_in  = rsp_stored_ff;

      if (csr_write && csr_index == CSR_DETECT_PERCENT) begin
         pct_in = csr_wdata[PCT_BITS-1:0];
      end

      // output register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               sens_in  = req_sensor_time;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            touched_in = (cmd_ff == CMD_SENSE) && (thr_scaled < sens_scaled);
            if (cmd_ff == CMD_CALIBRATE) begin
               if (sens_ff == '0) begin
                  ratio_in = RATIO_BITS'(RATIO_ZERO_SENSOR);
               end else if (div_quo > DVD_W'(RATIO_MAX)) begin
                  ratio_in = RATIO_BITS'(RATIO_MAX);
               end else begin
                  ratio_in = div_quo[RATIO_BITS-1:0];
               end
            end
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_touched_in = touched_ff;
               rsp_lamp_in    = hold_view.lamp_level;
               rsp_save_in    = hold_view.save_pulse;
               rsp_stored_in  = hold_view.stored_level;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ratio_ff     <= '0;
         pct_ff       <= PCT_BITS'(DETECT_PCT_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ratio_ff     <= ratio_in;
         pct_ff       <= pct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      sens_ff        <= sens_in;
      touched_ff     <= touched_in;
      rsp_touched_ff <= rsp_touched_in;
      rsp_lamp_ff    <= rsp_lamp_in;
      rsp_save_ff    <= rsp_save_in;
      rsp_stored_ff  <= rsp_stored_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_touched      = rsp_touched_ff;
   assign rsp_lamp_level   = rsp_lamp_ff;
   assign rsp_save_pulse   = rsp_save_ff;
   assign rsp_stored_level = rsp_stored_ff;

   // Checks
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_COMMIT))
      else $error("result appeared without a commit");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_calibrate_quiet: assert property (@(posedge clock) disable iff (reset)
      (commit && cmd_ff == CMD_CALIBRATE) |=> (!rsp_touched && !rsp_save_pulse))
      else $error("calibrate item reported a touch or a save");

endmodule

@@ sv/ctd_serial_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctd_serial_div #(
   parameter int DVD_W = 12,
   parameter int DVS_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0]   rem_shift;
   logic [DVS_W:0]   rem_diff;
   logic             fits;

   // One trial subtraction per cycle
   assign rem_shift = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign fits      = (rem_shift >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff : rem_shift;
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/ctd_hold.sv @@
// ----------------------------------------------------------------------------
// Touch-hold machine
// Tracks touch holding, steps the lamp level up, toggles and saves it.
// ----------------------------------------------------------------------------
module ctd_hold
   import ctd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  hold_req_type  req,
   output hold_view_type view
);

   logic                     holding_ff, holding_in;
   logic [LEVEL_BITS-1:0]    count_ff, count_in;
   logic [HOLD_MOD_BITS-1:0] mod_ff, mod_in;
   logic [LEVEL_BITS-1:0]    level_ff, level_in;
   logic [LEVEL_BITS-1:0]    saved_ff, saved_in;
   logic                     save;

   // Next state for a sense item; calibrate items leave everything alone
   always_comb begin
      holding_in = holding_ff;
      count_in   = count_ff;
      mod_in     = mod_ff;
      level_in   = level_ff;
      saved_in   = saved_ff;
      save       = 1'b0;
      if (req.sense) begin
         if (req.touched) begin
            if (!holding_ff) begin
               holding_in = 1'b1;
               count_in   = '0;
               mod_in     = '0;
            end else begin
               count_in = count_ff + LEVEL_BITS'(1);
               // count modulo five, kept alongside; wrap to zero restarts it
               if (count_in == '0 || mod_ff == HOLD_MOD_BITS'(HOLD_STEP - 1)) begin
                  mod_in = '0;
               end else begin
                  mod_in = mod_ff + HOLD_MOD_BITS'(1);
               end
               if (mod_in == '0) begin
                  level_in = {level_ff[LEVEL_BITS-2:0], 1'b1};
               end
            end
         end else if (holding_ff) begin
            holding_in = 1'b0;
            if (count_ff < LEVEL_BITS'(HOLD_STEP)) begin
               // short tap toggles the lamp
               level_in = (level_ff != '0) ? '0 : saved_ff;
            end else begin
               saved_in = level_ff;
               save     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff <= 1'b0;
         count_ff   <= '0;
         mod_ff     <= '0;
         level_ff   <= '0;
         saved_ff   <= '0;
      end else begin
         if (req.step) begin
            holding_ff <= holding_in;
            count_ff   <= count_in;
            mod_ff     <= mod_in;
            level_ff   <= level_in;
            saved_ff   <= saved_in;
         end
         if (req.load) begin
            saved_ff <= req.load_level;
         end
      end
   end

   assign view.lamp_level   = level_in;
   assign view.save_pulse   = save;
   assign view.stored_level = saved_in;

endmodule

@@ verif/capacitive_touch_dimmer_checker.sv @@
// ----------------------------------------------------------------------------
// Capacitive touch dimmer checker
// Watches the item, result and register channels of the dimmer. It predicts
// each result from its own copy of the ratio, hold machine and lamp levels,
// and compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module capacitive_touch_dimmer_checker
   import ctd_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [TIME_BITS-1:0]      req_ref_time,
   input  logic [TIME_BITS-1:0]      req_sensor_time,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_touched,
   input  logic [LEVEL_BITS-1:0]     rsp_lamp_level,
   input  logic                      rsp_save_pulse,
   input  logic [LEVEL_BITS-1:0]     rsp_stored_level,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // What one result item shows
   typedef struct packed {
      logic                  touched;
      logic [LEVEL_BITS-1:0] lamp_level;
      logic                  save_pulse;
      logic [LEVEL_BITS-1:0] stored_level;
   } lamp_view_type;

   // Predicted copy of the block state and settings
   logic [PCT_BITS-1:0]   detect_pct;
   logic [RATIO_BITS-1:0] charge_ratio;
   logic                  holding;
   logic [7:0]            hold_count;
   logic [LEVEL_BITS-1:0] level_now;
   logic [LEVEL_BITS-1:0] level_saved;

   lamp_view_type lamp_views_due[$];
   lamp_view_type oldest_view;

   // Calibrate or sense one item, advance the hold machine, return the view
   function automatic lamp_view_type advance_dimmer(input logic cmd,
                                                    input logic [TIME_BITS-1:0] rt,
                                                    input logic [TIME_BITS-1:0] st);
      lamp_view_type     view;
      longint unsigned   scaled;
      longint unsigned   quot;
      longint unsigned   divisor;
      longint unsigned   touch_limit;
      view   = '0;
      scaled = 64'(rt);
      scaled = scaled * 64'd10;
      if (cmd == CMD_CALIBRATE) begin
         if (st == 0) begin
            charge_ratio = RATIO_BITS'(RATIO_ZERO_SENSOR);
         end else begin
            quot = scaled / 64'(st);
            charge_ratio = (quot > RATIO_MAX) ? RATIO_BITS'(RATIO_MAX) : RATIO_BITS'(quot);
         end
      end else begin
         // a zero ratio divides as one
         divisor     = (charge_ratio == 0) ? 64'd1 : 64'(charge_ratio);
         touch_limit = (scaled / divisor) * 64'(PCT_BASE + detect_pct) / 64'(PCT_BASE);
         view.touched = (64'(st) > touch_limit);
         if (view.touched) begin
            if (!holding) begin
               holding    = 1'b1;
               hold_count = '0;
            end else begin
               hold_count = hold_count + 8'd1;
               if (hold_count % HOLD_STEP == 0)
                  level_now = {level_now[LEVEL_BITS-2:0], 1'b1};
            end
         end else if (holding) begin
            holding = 1'b0;
            // short touch toggles, long touch stores the level
            if (hold_count < HOLD_STEP) begin
               level_now = (level_now != 0) ? '0 : level_saved;
            end else begin
               level_saved     = level_now;
               view.save_pulse = 1'b1;
            end
         end
      end
      view.lamp_level   = level_now;
      view.stored_level = level_saved;
      return view;
   endfunction

   task automatic compare_view(input lamp_view_type want);
      if (rsp_touched !== want.touched) begin
         $error("touched: expected %0d, got %0d", want.touched, rsp_touched);
         fail_count++;
      end
      if (rsp_lamp_level !== want.lamp_level) begin
         $error("lamp_level: expected %0d, got %0d", want.lamp_level, rsp_lamp_level);
         fail_count++;
      end
      if (rsp_save_pulse !== want.save_pulse) begin
         $error("save_pulse: expected %0d, got %0d", want.save_pulse, rsp_save_pulse);
         fail_count++;
      end
      if (rsp_stored_level !== want.stored_level) begin
         $error("stored_level: expected %0d, got %0d", want.stored_level, rsp_stored_level);
         fail_count++;
      end
   endtask

   // Channel monitor: register writes, accepted items, accepted results
   always @(posedge clock) begin
      if (reset) begin
         detect_pct   = PCT_BITS'(DETECT_PCT_RST);
         charge_ratio = '0;
         holding      = 1'b0;
         hold_count   = '0;
         level_now    = '0;
         level_saved  = '0;
         lamp_views_due.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DETECT_PERCENT)
               detect_pct = csr_wdata[PCT_BITS-1:0];
            else if (csr_index == CSR_STARTUP_LEVEL)
               level_saved = csr_wdata;
         end
         if (req_valid && !req_stall)
            lamp_views_due.push_back(advance_dimmer(req_cmd, req_ref_time, req_sensor_time));
         if (rsp_valid && !rsp_stall) begin
            if (lamp_views_due.size() == 0) begin
               $error("result item with no item outstanding: lamp_level %0d", rsp_lamp_level);
               fail_count++;
            end else begin
               oldest_view = lamp_views_due.pop_front();
               compare_view(oldest_view);
            end
         end
         pending <= lamp_views_due.size();
      end
   end

endmodule

@@ verif/tb_capacitive_touch_dimmer.sv @@
// ----------------------------------------------------------------------------
// Capacitive touch dimmer testbench
// Drives calibrate and sense items into the dimmer: a directed opening, then
// random phases of touch-and-release sequences with noise, under several
// register settings, random idling on both channels and one long output
// hold-off. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_capacitive_touch_dimmer;
   timeunit 1ns;
   timeprecision 1ps;
   import ctd_pkg::*;

   localparam int TIME_BITS      = TIME_BITS_DEF;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 25;
   localparam int LIMIT_NS       = 8_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_cmd = CMD_CALIBRATE;
   logic [TIME_BITS-1:0]      req_ref_time = '0;
   logic [TIME_BITS-1:0]      req_sensor_time = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_touched;
   logic [LEVEL_BITS-1:0]     rsp_lamp_level;
   logic                      rsp_save_pulse;
   logic [LEVEL_BITS-1:0]     rsp_stored_level;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   int                        fail_count;
   int                        pending;

   // Stimulus control; quiet and squeeze_req are shared with the receiver
   bit  quiet = 1'b0;
   int  squeeze_req = 0;
   bit  tx_bursty = 1'b1;
   int  items_sent = 0;
   int  cal_ref = 0;
   int  cal_sens = 1;
   bit  cal_fresh = 1'b0;

   capacitive_touch_dimmer #(.TIME_BITS(TIME_BITS)) DUT (.*);

   capacitive_touch_dimmer_checker #(.TIME_BITS(TIME_BITS)) lamp_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(LIMIT_NS);
      $display("tb_capacitive_touch_dimmer NOT OK");
      $finish;
   end

   // Offer one item and hold it until accepted; sometimes idle afterwards
   task automatic send_item(input logic cmd, input int rt, input int st);
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_ref_time    <= TIME_BITS'(rt);
      req_sensor_time <= TIME_BITS'(st);
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (items_sent % 64 == 0)
         tx_bursty = 1'($urandom_range(0, 1));
      if (!quiet && tx_bursty && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Let every outstanding result come out, then let the block go idle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Calibrate so that sensor <= cal_sens never touches and >= 3*cal_sens
   // always does, whatever the detect percent
   task automatic recalibrate();
      cal_sens = $urandom_range(1, 85);
      cal_ref  = $urandom_range(cal_sens, 255);
      send_item(CMD_CALIBRATE, cal_ref, cal_sens);
      cal_fresh = 1'b1;
   endtask

   task automatic touch_hold(input int len);
      repeat (len) send_item(CMD_SENSE, cal_ref, $urandom_range(3 * cal_sens, 255));
      send_item(CMD_SENSE, cal_ref, $urandom_range(0, cal_sens));
   endtask

   // Mostly touch-and-release sequences, some fully random items
   task automatic run_mix(input int n);
      int sent;
      int pick;
      int len;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            send_item(1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 255));
            cal_fresh = 1'b0;
            sent++;
         end else begin
            if (pick < 7 || !cal_fresh) begin
               recalibrate();
               sent++;
            end
            len = (pick < 14) ? $urandom_range(1, HOLD_STEP - 1) : $urandom_range(HOLD_STEP, 30);
            touch_hold(len);
            sent += len + 1;
         end
      end
   endtask

   // Result side: random stall bursts in changing stretches, plus one long hold-off
   initial begin : rsp_side
      int  burst = 0;
      int  squeeze = 0;
      int  stretch = 0;
      int  squeeze_seen = 0;
      bit  bursty = 1'b1;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            bursty  = 1'($urandom_range(0, 1));
            stretch = $urandom_range(50, 300);
         end else begin
            stretch--;
         end
         if (squeeze_seen != squeeze_req) begin
            squeeze_seen = squeeze_req;
            squeeze      = SQUEEZE_CYCLES;
         end
         if (squeeze != 0) begin
            squeeze--;
            rsp_stall <= 1'b1;
         end else if (burst != 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && bursty && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 8) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Main sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings; zero ratio first, then the edge cases
      send_item(CMD_SENSE, 255, 255);
      send_item(CMD_SENSE, 0, 1);
      send_item(CMD_SENSE, 0, 0);
      send_item(CMD_CALIBRATE, 255, 0);       // zero sensor time
      send_item(CMD_SENSE, 255, 2);
      send_item(CMD_SENSE, 255, 1);
      send_item(CMD_CALIBRATE, 255, 1);       // largest quotient
      send_item(CMD_CALIBRATE, 0, 255);       // ratio of zero
      send_item(CMD_CALIBRATE, 100, 100);
      send_item(CMD_SENSE, 100, 126);         // just over the threshold
      send_item(CMD_SENSE, 100, 125);         // just at it
      send_item(CMD_SENSE, 100, 255);
      repeat (6) send_item(CMD_SENSE, 100, 200);
      send_item(CMD_SENSE, 100, 125);         // long release saves
      send_item(CMD_SENSE, 100, 255);
      send_item(CMD_SENSE, 100, 0);           // short touch turns off
      send_item(CMD_SENSE, 100, 255);
      send_item(CMD_SENSE, 100, 0);           // short touch restores saved
      send_item(CMD_CALIBRATE, 0, 0);
      drain();

      // lowest percent, full startup level
      write_reg(CSR_DETECT_PERCENT, 8'h00);
      write_reg(CSR_STARTUP_LEVEL, 8'hFF);
      run_mix(440);
      drain();

      // percent past 100 with the unused top bit set; hold long enough to reach the count's top or wrap
      write_reg(CSR_DETECT_PERCENT, 8'hFF);
      write_reg(CSR_STARTUP_LEVEL, 8'h5A);
      run_mix(200);
      recalibrate();
      touch_hold($urandom_range(256, 265));
      run_mix(200);
      drain();

      // percent 100; the receiver holds off while items keep coming
      write_reg(CSR_DETECT_PERCENT, 8'hE4);
      write_reg(CSR_STARTUP_LEVEL, 8'h00);
      run_mix(150);
      quiet = 1'b1;
      squeeze_req++;
      run_mix(30);
      quiet = 1'b0;
      run_mix(250);
      drain();

      // random settings, then a final stretch with no idling
      write_reg(CSR_DETECT_PERCENT, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 127))});
      write_reg(CSR_STARTUP_LEVEL, 8'($urandom_range(0, 255)));
      run_mix(250);
      quiet = 1'b1;
      run_mix(200);
      drain();

      if (fail_count == 0)
         $display("tb_capacitive_touch_dimmer OK");
      else
         $display("tb_capacitive_touch_dimmer NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/ctd_pkg.sv
sv/ctd_serial_div.sv
sv/ctd_hold.sv
sv/capacitive_touch_dimmer.sv
verif/capacitive_touch_dimmer_checker.sv
verif/tb_capacitive_touch_dimmer.sv
